>>> hw/rtl/assert_macros.svh
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at the same clock edge
`define ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked at the next clock edge
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/btpc_pkg.sv
// types, constants and helpers of the barometer compensation core
package btpc_pkg;

    localparam int unsigned NumStages = 45;
    localparam int unsigned DivFirst  = 10;
    localparam int unsigned DivLast   = 41;

    typedef enum logic [1:0] {
        REG_TEMP_CALIB       = 2'd0,
        REG_PRESS_CALIB_LOW  = 2'd1,
        REG_PRESS_CALIB_HIGH = 2'd2,
        REG_PRESS_CALIB_NINE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [19:0] raw_temperature;
        logic [19:0] raw_pressure;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic signed [31:0] fine_temperature;
        logic [31:0]        pressure_pa;
        logic               divide_by_zero;
    } out_item_t;

    typedef struct packed {
        logic [19:0] rp;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] fine;
        logic [31:0] centi;
        logic [31:0] v1;
        logic [31:0] v2;
        logic [31:0] m1;
        logic [31:0] m2;
        logic [31:0] m3;
        logic [31:0] dv;
        logic [31:0] p;
        logic [31:0] r;
        logic [31:0] q;
        logic        post;
        logic        dz;
    } stage_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] half_s(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

endpackage

>>> hw/rtl/baro_temp_press_compensation_core.sv
// an accepted input transaction passes through every pipeline stage before its result reaches m_
// throughput: one transaction per cycle while the output is not stalled; the 32-stage restoring divider sets the depth
// a stalled output holds the whole pipeline in place
// reset: aresetn synchronous active low clears valid bits and calibration registers
`include "assert_macros.svh"
module baro_temp_press_compensation_core
    import btpc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  logic [63:0] cfg_wdata
);

    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    stage_t st_reg  [NumStages];
    stage_t st_next [NumStages];
    logic [NumStages-1:0] vld_reg;
    logic adv;

    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = {16'd0, temp_calib_reg[15:0]};
    assign t2 = half_s(temp_calib_reg[31:16]);
    assign t3 = half_s(temp_calib_reg[47:32]);
    assign p1 = {16'd0, press_low_reg[15:0]};
    assign p2 = half_s(press_low_reg[31:16]);
    assign p3 = half_s(press_low_reg[47:32]);
    assign p4 = half_s(press_low_reg[63:48]);
    assign p5 = half_s(press_high_reg[15:0]);
    assign p6 = half_s(press_high_reg[31:16]);
    assign p7 = half_s(press_high_reg[47:32]);
    assign p8 = half_s(press_high_reg[63:48]);
    assign p9 = half_s(press_nine_reg);

    assign adv     = !vld_reg[NumStages-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NumStages-1];
    assign m_data.temperature_centi = $signed(st_reg[NumStages-1].centi);
    assign m_data.fine_temperature  = $signed(st_reg[NumStages-1].fine);
    assign m_data.pressure_pa       = st_reg[NumStages-1].p;
    assign m_data.divide_by_zero    = st_reg[NumStages-1].dz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_nine_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TEMP_CALIB:       temp_calib_reg <= cfg_wdata[47:0];
                REG_PRESS_CALIB_LOW:  press_low_reg  <= cfg_wdata;
                REG_PRESS_CALIB_HIGH: press_high_reg <= cfg_wdata;
                REG_PRESS_CALIB_NINE: press_nine_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [31:0] x0;
        logic [31:0] y0;
        logic [31:0] q0;
        logic [32:0] r2;
        stage_t c;
        x0 = '0;
        y0 = '0;
        q0 = '0;
        r2 = '0;
        c  = '0;
        for (int i = 0; i < NumStages; i++) begin
            if (i == 0) begin
                c    = '0;
                c.rp = s_data.raw_pressure;
                x0   = {15'd0, s_data.raw_temperature[19:3]} - (t1 << 1);
                y0   = {16'd0, s_data.raw_temperature[19:4]} - t1;
                c.a  = x0 * t2;
                c.b  = y0 * y0;
            end else begin
                c = st_reg[i-1];
                if (i == 1) begin
                    c.a = asr(st_reg[0].a, 11);
                    c.b = asr(st_reg[0].b, 12) * t3;
                end else if (i == 2) begin
                    c.fine = st_reg[1].a + asr(st_reg[1].b, 14);
                end else if (i == 3) begin
                    c.centi = asr(st_reg[2].fine * 32'd5 + 32'd128, 8);
                    c.v1    = asr(st_reg[2].fine, 1) - 32'd64000;
                end else if (i == 4) begin
                    q0   = asr(st_reg[3].v1, 2);
                    c.m1 = q0 * q0;
                    c.m2 = st_reg[3].v1 * p5;
                    c.m3 = p2 * st_reg[3].v1;
                end else if (i == 5) begin
                    c.m1 = asr(st_reg[4].m1, 11) * p6;
                    c.m3 = p3 * asr(st_reg[4].m1, 13);
                    c.a  = st_reg[4].m3;
                end else if (i == 6) begin
                    c.v2 = asr(st_reg[5].m1 + (st_reg[5].m2 << 1), 2) + (p4 << 16);
                    c.v1 = asr(asr(st_reg[5].m3, 3) + asr(st_reg[5].a, 1), 18);
                end else if (i == 7) begin
                    c.dv = (32'd32768 + st_reg[6].v1) * p1;
                    c.p  = 32'd1048576 - {12'd0, st_reg[6].rp} - asr(st_reg[6].v2, 12);
                end else if (i == 8) begin
                    c.dv = asr(st_reg[7].dv, 15);
                    c.p  = st_reg[7].p * 32'd3125;
                    c.dz = (asr(st_reg[7].dv, 15) == 32'd0);
                end else if (i == DivFirst - 1) begin
                    c.post = st_reg[8].p[31];
                    c.q    = st_reg[8].p[31] ? st_reg[8].p : (st_reg[8].p << 1);
                    c.r    = '0;
                end else if (i <= DivLast) begin
                    r2 = {st_reg[i-1].r, st_reg[i-1].q[31]};
                    c.q = st_reg[i-1].q << 1;
                    if (r2 >= {1'b0, st_reg[i-1].dv}) begin
                        r2 = r2 - {1'b0, st_reg[i-1].dv};
                        c.q[0] = 1'b1;
                    end
                    c.r = r2[31:0];
                end else if (i == DivLast + 1) begin
                    c.p  = st_reg[i-1].post ? (st_reg[i-1].q << 1) : st_reg[i-1].q;
                    x0   = c.p >> 3;
                    c.m1 = x0 * x0;
                    c.m2 = (c.p >> 2) * p8;
                end else if (i == DivLast + 2) begin
                    c.m3 = p9 * (st_reg[i-1].m1 >> 13);
                end else begin
                    c.p = st_reg[i-1].dz ? 32'd0 :
                          st_reg[i-1].p + asr(asr(st_reg[i-1].m3, 12) +
                          asr(st_reg[i-1].m2, 13) + p7, 4);
                end
            end
            st_next[i] = c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NumStages-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < NumStages; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    `ASSERT_SAME(a_dz_zero, aclk, aresetn, m_valid && m_data.divide_by_zero,
        m_data.pressure_pa == 32'd0, "pressure not zero on zero divisor")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid,
        "result dropped while stalled")
    `ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, vld_reg[0],
        "accepted transaction not in first stage")

endmodule

>>> tb/baro_temp_press_compensation_checker.sv
// checker for the barometer compensation core: predicts each result and compares it
module baro_temp_press_compensation_checker
    import btpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_data,
    input  logic        cfg_we,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_wdata,
    output int          n_errors,
    output int          n_pending
);

    logic [47:0] temp_coef;
    logic [63:0] press_coef_lo;
    logic [63:0] press_coef_hi;
    logic [15:0] press_coef_p9;
    out_item_t   pending_results[$];

    function automatic logic [31:0] sra(input logic [31:0] x, input int s);
        return $unsigned($signed(x) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

    function automatic out_item_t compensate(input in_item_t it);
        logic [31:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] a, b, fine, centi, v1, v2, q2, dv, p, press;
        out_item_t r;
        rt = {12'd0, it.raw_temperature};
        rp = {12'd0, it.raw_pressure};
        t1 = {16'd0, temp_coef[15:0]};
        t2 = sx16(temp_coef[31:16]);
        t3 = sx16(temp_coef[47:32]);
        p1 = {16'd0, press_coef_lo[15:0]};
        p2 = sx16(press_coef_lo[31:16]);
        p3 = sx16(press_coef_lo[47:32]);
        p4 = sx16(press_coef_lo[63:48]);
        p5 = sx16(press_coef_hi[15:0]);
        p6 = sx16(press_coef_hi[31:16]);
        p7 = sx16(press_coef_hi[47:32]);
        p8 = sx16(press_coef_hi[63:48]);
        p9 = sx16(press_coef_p9);
        a = (rt >> 3) - (t1 << 1);
        a = sra(a * t2, 11);
        b = (rt >> 4) - t1;
        b = sra(sra(b * b, 12) * t3, 14);
        fine = a + b;
        centi = sra(fine * 32'd5 + 32'd128, 8);
        v1 = sra(fine, 1) - 32'd64000;
        q2 = sra(v1, 2) * sra(v1, 2);
        v2 = sra(q2, 11) * p6;
        v2 = v2 + ((v1 * p5) << 1);
        v2 = sra(v2, 2) + (p4 << 16);
        v1 = sra(sra(p3 * sra(q2, 13), 3) + sra(p2 * v1, 1), 18);
        dv = sra((32'd32768 + v1) * p1, 15);
        r.temperature_centi = centi;
        r.fine_temperature = fine;
        if (dv == 0) begin
            r.pressure_pa = '0;
            r.divide_by_zero = 1'b1;
        end else begin
            p = ((32'd1048576 - rp) - sra(v2, 12)) * 32'd3125;
            if (p < 32'h8000_0000) p = (p << 1) / dv;
            else p = (p / dv) << 1;
            v1 = sra(p9 * (((p >> 3) * (p >> 3)) >> 13), 12);
            v2 = sra((p >> 2) * p8, 13);
            press = p + sra(v1 + v2 + p7, 4);
            r.pressure_pa = press;
            r.divide_by_zero = 1'b0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            temp_coef <= '0;
            press_coef_lo <= '0;
            press_coef_hi <= '0;
            press_coef_p9 <= '0;
            n_errors <= 0;
            n_pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TEMP_CALIB:       temp_coef <= cfg_wdata[47:0];
                    REG_PRESS_CALIB_LOW:  press_coef_lo <= cfg_wdata;
                    REG_PRESS_CALIB_HIGH: press_coef_hi <= cfg_wdata;
                    REG_PRESS_CALIB_NINE: press_coef_p9 <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) pending_results.push_back(compensate(s_data));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    if (n_errors < 10) $display("unexpected result %h", m_data);
                    n_errors <= n_errors + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (want !== m_data) begin
                        if (n_errors < 10) begin
                            $display("mismatch: expected c=%0d f=%0d p=%0d z=%b",
                                want.temperature_centi, want.fine_temperature,
                                want.pressure_pa, want.divide_by_zero);
                            $display("          got c=%0d f=%0d p=%0d z=%b",
                                m_data.temperature_centi, m_data.fine_temperature,
                                m_data.pressure_pa, m_data.divide_by_zero);
                        end
                        n_errors <= n_errors + 1;
                    end
                end
            end
            n_pending <= pending_results.size();
        end
    end

endmodule

>>> tb/baro_temp_press_compensation_core_test.sv
// stimulus and verdict for the barometer compensation core
module baro_temp_press_compensation_core_test;
    import btpc_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    cfg_index_t  cfg_index = REG_TEMP_CALIB;
    logic [63:0] cfg_wdata = '0;
    int          n_errors;
    int          n_pending;
    int          n_cycles = 0;
    logic        hold_off = 1'b0;

    baro_temp_press_compensation_core i_dut (.*);

    baro_temp_press_compensation_checker i_checker (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 400000) begin
            $display("baro_temp_press_compensation_core regression: fail");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    initial begin
        int n;
        while (1) begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (n_cycles % 3000 < 800) begin
                m_ready <= 1'b1;
            end else begin
                n = gap_len();
                m_ready <= (n == 0);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic send(input logic [19:0] rt, input logic [19:0] rp);
        int n;
        n = (n_cycles % 2500 < 600) ? 0 : gap_len();
        if (n != 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{raw_temperature: rt, raw_pressure: rp};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // calibration sets by mode: typical, all ones, extreme halves, fully random, or typical with random perturbation
    task automatic set_calib(input int mode);
        logic [63:0] t, pl, ph, p9;
        if (mode == 0) begin
            t = {16'd0, 16'd50, 16'd26435, 16'd27504};
            pl = {16'd2855, -16'sd10, 16'd8, 16'd36477};
            ph = {-16'sd7000, 16'd15500, -16'sd7, -16'sd7};
            ph = {16'hc0be, 16'h3c8c, 16'hfff9, 16'h008c};
            p9 = 64'd4000;
        end else if (mode == 1) begin
            t = '1; pl = '1; ph = '1; p9 = 64'hffff;
        end else if (mode == 2) begin
            t = {16'd0, 16'h7fff, 16'h8000, 16'h7fff};
            pl = {16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
            ph = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
            p9 = 64'h7fff;
        end else if (mode == 3) begin
            t = {$urandom, $urandom};
            pl = {$urandom, $urandom};
            ph = {$urandom, $urandom};
            p9 = {$urandom, $urandom};
        end else begin
            t = {16'd0, 16'd50 + 16'($urandom_range(0, 20)), 16'd26435,
                 16'd27000 + 16'($urandom_range(0, 999))};
            pl = {16'd2855, -16'sd10, 16'd8 + 16'($urandom_range(0, 5)),
                  16'd36000 + 16'($urandom_range(0, 999))};
            ph = {16'hc0be, 16'h3c8c, 16'hfff9, 16'h0080 + 16'($urandom_range(0, 31))};
            p9 = {$urandom, $urandom};
        end
        write_reg(REG_TEMP_CALIB, t);
        write_reg(REG_PRESS_CALIB_LOW, pl);
        write_reg(REG_PRESS_CALIB_HIGH, ph);
        write_reg(REG_PRESS_CALIB_NINE, p9);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // reset coefficients give a zero divisor
        send(20'd0, 20'd0);
        send(20'hfffff, 20'hfffff);
        drain();
        for (int m = 0; m < 5; m++) begin
            set_calib(m);
            send(20'd0, 20'd0);
            send(20'hfffff, 20'hfffff);
            send(20'd519888, 20'd415148);
            send(20'h55555, 20'haaaaa);
            drain();
        end
        // p1 zero forces a zero divisor with live temperature
        set_calib(0);
        write_reg(REG_PRESS_CALIB_LOW, 64'h0b27_fff6_0008_0000);
        send(20'd519888, 20'd415148);
        drain();
        for (int ph = 0; ph < 8; ph++) begin
            set_calib(ph < 4 ? 4 : (ph == 4 ? 3 : ph - 5 < 2 ? ph - 5 : 4));
            if (ph == 2) begin
                fork
                    begin
                        @(posedge aclk);
                        hold_off <= 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_off <= 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < 200; k++) begin
                if ($urandom_range(0, 9) < 8)
                    send(20'd480000 + 20'($urandom_range(0, 80000)),
                         20'd250000 + 20'($urandom_range(0, 250000)));
                else
                    send(20'($urandom), 20'($urandom));
            end
            drain();
        end
        @(posedge aclk);
        if (n_errors == 0 && n_pending == 0)
            $display("baro_temp_press_compensation_core regression: pass");
        else
            $display("baro_temp_press_compensation_core regression: fail");
        $finish;
    end

endmodule
